FILE: sv/ipc_pkg.sv
// Shared types and constants of the interrupt priority controller.
package ipc_pkg;

  localparam int DEF_NUM_SOURCES   = 64;
  localparam int DEF_PRIORITY_BITS = 3;
  localparam int WORD_BITS         = 32;
  localparam int CFG_WIDTH         = 3;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SPACE_PRIORITY = 2'd0,
    SPACE_ENABLE   = 2'd1,
    SPACE_CLAIM    = 2'd2
  } space_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT,
    ST_EXEC,
    ST_SETTLE,
    ST_CAPTURE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  source_number;
    logic [1:0]  register_space;
    logic [5:0]  register_index;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        interrupt_line;
    logic        access_error;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic execute;
    logic capture;
  } cmd_t;

endpackage

FILE: sv/interrupt_priority_controller_unit.sv
// Top level of the interrupt priority controller for one target.
//
// Command channel: a transaction (source request, bus write or bus read) is
// taken on a rising edge with start_i high and busy_o low. Exactly one result
// follows on rsp_o, valid for the single cycle in which done_o is high; the
// receiver cannot hold it off, so it must sample it in that cycle.
// The transaction passes the wait, exec, settle and capture states in order,
// and done_o is registered from the capture state. No new transaction is
// taken while one is in flight; busy_o falls in the cycle done_o is high,
// so the next one may be accepted at the edge that takes the previous result.
// Wait and settle serve the arbitration tree, which has one register stage:
// it settles once before a claim is resolved and once more after the source
// state is updated, so that interrupt_line reflects the post-update state.
// Threshold register: cfg_we_i writes cfg_wdata_i at once, no wait; write it
// only while no transaction is in flight.
// Reset clears all priorities, enables, pending and in-service bits and the
// threshold, and leaves the block idle.
module interrupt_priority_controller_unit #(
  parameter int NUM_SOURCES   = ipc_pkg::DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = ipc_pkg::DEF_PRIORITY_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  ipc_pkg::req_t                  req_i,
  output logic                           done_o,
  output ipc_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_we_i,
  input  logic [ipc_pkg::CFG_WIDTH-1:0]  cfg_wdata_i
);
  import ipc_pkg::*;

  cmd_t cmd;

  ipc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  ipc_datapath #(
    .NUM_SOURCES   (NUM_SOURCES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule

FILE: sv/ipc_ctrl.sv
// Transaction sequencer of the interrupt priority controller.
module ipc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  output ipc_pkg::cmd_t cmd_o
);
  import ipc_pkg::*;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_SETTLE;
      end
      ST_SETTLE: begin
        state_d = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd_o.capture = 1'b1;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

FILE: sv/ipc_arb_tree.sv
// Registered priority arbitration tree over all interrupt sources.
module ipc_arb_tree #(
  parameter int NUM_SOURCES   = ipc_pkg::DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = ipc_pkg::DEF_PRIORITY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [NUM_SOURCES-1:0]           cand_i,
  input  logic [PRIORITY_BITS-1:0]         prio_i [NUM_SOURCES],
  output logic                             root_valid_o,
  output logic [$clog2(NUM_SOURCES)-1:0]   root_id_o
);
  import ipc_pkg::*;

  localparam int IDW    = $clog2(NUM_SOURCES);
  localparam int LEVELS = IDW;
  localparam int NP     = 2 ** LEVELS;
  localparam int NODES  = 2 * NP - 1;
  localparam int CUT    = LEVELS / 2;

  logic                     nv  [NODES];
  logic [PRIORITY_BITS-1:0] np  [NODES];
  logic [IDW-1:0]           nid [NODES];

  for (genvar i = 0; i < NODES; i++) begin : g_node
    if (i >= NP - 1) begin : g_leaf
      localparam int J = i - (NP - 1);
      if (J < NUM_SOURCES) begin : g_real
        assign nv[i]  = cand_i[J];
        assign np[i]  = prio_i[J];
        assign nid[i] = IDW'(J);
      end else begin : g_pad
        assign nv[i]  = 1'b0;
        assign np[i]  = '0;
        assign nid[i] = '0;
      end
    end else begin : g_inner
      localparam int DEPTH = $clog2(i + 2) - 1;
      logic                     sel_right;
      logic                     m_v;
      logic [PRIORITY_BITS-1:0] m_p;
      logic [IDW-1:0]           m_id;

      assign sel_right = nv[2*i+2] && (!nv[2*i+1] || (np[2*i+2] > np[2*i+1]));
      assign m_v       = nv[2*i+1] | nv[2*i+2];
      assign m_p       = sel_right ? np[2*i+2] : np[2*i+1];
      assign m_id      = sel_right ? nid[2*i+2] : nid[2*i+1];

      if (DEPTH == CUT) begin : g_reg
        logic                     v_q;
        logic [PRIORITY_BITS-1:0] p_q;
        logic [IDW-1:0]           id_q;

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            v_q <= 1'b0;
          end else begin
            v_q <= m_v;
          end
        end

        always_ff @(posedge clk_i) begin
          p_q  <= m_p;
          id_q <= m_id;
        end

        assign nv[i]  = v_q;
        assign np[i]  = p_q;
        assign nid[i] = id_q;
      end else begin : g_comb
        assign nv[i]  = m_v;
        assign np[i]  = m_p;
        assign nid[i] = m_id;
      end
    end
  end

  assign root_valid_o = nv[0];
  assign root_id_o    = nid[0];

endmodule

FILE: sv/ipc_datapath.sv
// Source state, register access logic and result registers of the controller.
module ipc_datapath #(
  parameter int NUM_SOURCES   = ipc_pkg::DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = ipc_pkg::DEF_PRIORITY_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ipc_pkg::cmd_t                  cmd_i,
  input  ipc_pkg::req_t                  req_i,
  input  logic                           cfg_we_i,
  input  logic [ipc_pkg::CFG_WIDTH-1:0]  cfg_wdata_i,
  output ipc_pkg::rsp_t                  rsp_o
);
  import ipc_pkg::*;

  localparam int IDW = $clog2(NUM_SOURCES);
  localparam int EW  = (NUM_SOURCES + WORD_BITS - 1) / WORD_BITS;

  req_t                     req_q;
  logic [PRIORITY_BITS-1:0] thr_q;
  logic [PRIORITY_BITS-1:0] prio_q [NUM_SOURCES];
  logic [PRIORITY_BITS-1:0] prio_d [NUM_SOURCES];
  logic [NUM_SOURCES-1:0]   en_q, en_d;
  logic [NUM_SOURCES-1:0]   pend_q, pend_d;
  logic [NUM_SOURCES-1:0]   insvc_q, insvc_d;
  logic [31:0]              rval_q, rval_d;
  logic                     err_q, err_d;
  logic                     irq_q;

  logic [NUM_SOURCES-1:0]   cand;
  logic                     root_valid;
  logic [IDW-1:0]           root_id;
  logic [IDW-1:0]           claim_s;
  logic [EW*WORD_BITS-1:0]  en_pad;
  logic [IDW-1:0]           idx_s, src_s, cpl_s;
  logic                     idx_ok, src_ok, word_ok, cpl_ok;

  for (genvar s = 0; s < NUM_SOURCES; s++) begin : g_cand
    assign cand[s] = en_q[s] & pend_q[s] & (prio_q[s] > thr_q);
  end

  ipc_arb_tree #(
    .NUM_SOURCES   (NUM_SOURCES),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_i       (cand),
    .prio_i       (prio_q),
    .root_valid_o (root_valid),
    .root_id_o    (root_id)
  );

  assign idx_ok  = 32'(req_q.register_index) < NUM_SOURCES;
  assign word_ok = 32'(req_q.register_index) < EW;
  assign src_ok  = 32'(req_q.source_number) < NUM_SOURCES;
  assign cpl_ok  = req_q.write_value < 32'(NUM_SOURCES);
  assign idx_s   = IDW'(req_q.register_index);
  assign src_s   = IDW'(req_q.source_number);
  assign cpl_s   = IDW'(req_q.write_value);
  assign claim_s = root_valid ? root_id : '0;
  assign en_pad  = (EW*WORD_BITS)'(en_q);

  always_comb begin
    prio_d  = prio_q;
    en_d    = en_q;
    pend_d  = pend_q;
    insvc_d = insvc_q;
    rval_d  = rval_q;
    err_d   = err_q;
    if (cmd_i.execute) begin
      rval_d = '0;
      err_d  = 1'b0;
      case (req_q.kind)
        KIND_REQUEST: begin
          if (!src_ok) begin
            err_d = 1'b1;
          end else if (src_s != '0 && !pend_q[src_s] && !insvc_q[src_s]) begin
            pend_d[src_s] = 1'b1;
          end
        end
        KIND_WRITE, KIND_READ: begin
          case (req_q.register_space)
            SPACE_PRIORITY: begin
              if (!idx_ok) begin
                err_d = 1'b1;
              end else if (req_q.kind == KIND_WRITE) begin
                if (idx_s != '0) begin
                  prio_d[idx_s] = req_q.write_value[PRIORITY_BITS-1:0];
                end
              end else begin
                rval_d = 32'(prio_q[idx_s]);
              end
            end
            SPACE_ENABLE: begin
              if (!word_ok) begin
                err_d = 1'b1;
              end else if (req_q.kind == KIND_WRITE) begin
                for (int s = 1; s < NUM_SOURCES; s++) begin
                  if (s / WORD_BITS == 32'(req_q.register_index)) begin
                    en_d[s] = req_q.write_value[s % WORD_BITS];
                  end
                end
              end else begin
                for (int w = 0; w < EW; w++) begin
                  if (32'(req_q.register_index) == w) begin
                    rval_d = en_pad[w*WORD_BITS +: WORD_BITS];
                  end
                end
              end
            end
            SPACE_CLAIM: begin
              if (req_q.kind == KIND_WRITE) begin
                if (!cpl_ok) begin
                  err_d = 1'b1;
                end else if (cpl_s != '0) begin
                  insvc_d[cpl_s] = 1'b0;
                end
              end else begin
                if (root_valid) begin
                  pend_d[root_id]  = 1'b0;
                  insvc_d[root_id] = 1'b1;
                end
                rval_d = 32'(claim_s);
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      en_q    <= '0;
      pend_q  <= '0;
      insvc_q <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        prio_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= PRIORITY_BITS'(cfg_wdata_i);
      end
      en_q    <= en_d;
      pend_q  <= pend_d;
      insvc_q <= insvc_d;
      prio_q  <= prio_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    rval_q <= rval_d;
    err_q  <= err_d;
    if (cmd_i.capture) begin
      irq_q <= root_valid;
    end
  end

  assign rsp_o.read_value     = rval_q;
  assign rsp_o.interrupt_line = irq_q;
  assign rsp_o.access_error   = err_q;

endmodule

FILE: test/tb_top.sv
// Testbench for the interrupt priority controller: directed table, then random traffic.
module tb_top;
  import ipc_pkg::*;

  localparam int NUM_SRC     = DEF_NUM_SOURCES;
  localparam int PRI_BITS    = DEF_PRIORITY_BITS;
  localparam int EN_WORDS    = (NUM_SRC + WORD_BITS - 1) / WORD_BITS;
  localparam int STALL_LIMIT = 200;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 260;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam logic [1:0] SPACE_UNUSED = 2'd3;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  req_t                 req_i;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i;
  logic [CFG_WIDTH-1:0] cfg_wdata_i;

  logic [PRI_BITS-1:0]  level_q      [NUM_SRC];
  bit                   enable_q     [NUM_SRC];
  bit                   pending_q    [NUM_SRC];
  bit                   in_service_q [NUM_SRC];
  logic [CFG_WIDTH-1:0] threshold_q;

  rsp_t rsp_backlog [$];
  int   mismatch_count;
  bit   idle_on;

  interrupt_priority_controller_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [5:0] winning_source();
    logic [5:0]          id;
    logic [PRI_BITS-1:0] lvl;
    id  = '0;
    lvl = threshold_q;
    for (int s = 1; s < NUM_SRC; s++) begin
      if (enable_q[s] && pending_q[s] && level_q[s] > lvl) begin
        id  = s[5:0];
        lvl = level_q[s];
      end
    end
    return id;
  endfunction

  function automatic rsp_t apply_transaction(req_t r);
    rsp_t       o;
    logic [5:0] id;
    int         s;
    o = '0;
    case (r.kind)
      KIND_REQUEST: begin
        if (r.source_number >= NUM_SRC) begin
          o.access_error = 1'b1;
        end else if (r.source_number != 0 && !pending_q[r.source_number] &&
                     !in_service_q[r.source_number]) begin
          pending_q[r.source_number] = 1'b1;
        end
      end
      KIND_WRITE, KIND_READ: begin
        case (r.register_space)
          SPACE_PRIORITY: begin
            if (r.register_index >= NUM_SRC) begin
              o.access_error = 1'b1;
            end else if (r.kind == KIND_WRITE) begin
              if (r.register_index != 0)
                level_q[r.register_index] = r.write_value[PRI_BITS-1:0];
            end else begin
              o.read_value = 32'(level_q[r.register_index]);
            end
          end
          SPACE_ENABLE: begin
            if (r.register_index >= EN_WORDS) begin
              o.access_error = 1'b1;
            end else begin
              for (int b = 0; b < WORD_BITS; b++) begin
                s = int'(r.register_index) * WORD_BITS + b;
                if (s < NUM_SRC) begin
                  if (r.kind == KIND_WRITE) begin
                    if (s != 0) enable_q[s] = r.write_value[b];
                  end else begin
                    o.read_value[b] = enable_q[s];
                  end
                end
              end
            end
          end
          SPACE_CLAIM: begin
            if (r.kind == KIND_WRITE) begin
              if (r.write_value >= NUM_SRC) begin
                o.access_error = 1'b1;
              end else if (r.write_value != 0) begin
                in_service_q[r.write_value] = 1'b0;
              end
            end else begin
              id = winning_source();
              if (id != 0) begin
                pending_q[id]    = 1'b0;
                in_service_q[id] = 1'b1;
              end
              o.read_value = 32'(id);
            end
          end
          default: o.access_error = 1'b1;
        endcase
      end
      default: o.access_error = 1'b1;
    endcase
    o.interrupt_line = (winning_source() != 0);
    return o;
  endfunction

  function automatic row_t row(logic [1:0] k, logic [5:0] src, logic [1:0] sp,
                               logic [5:0] idx, logic [31:0] wv, bit typed,
                               logic [31:0] rv, bit irq, bit err);
    row_t t;
    t.req.kind                = k;
    t.req.source_number       = src;
    t.req.register_space      = sp;
    t.req.register_index      = idx;
    t.req.write_value         = wv;
    t.typed                   = typed;
    t.want.read_value         = rv;
    t.want.interrupt_line     = irq;
    t.want.access_error       = err;
    return t;
  endfunction

  function automatic req_t random_txn();
    req_t r;
    int   sel;
    int   busy_ids [$];
    r.kind           = 2'($urandom_range(3));
    r.source_number  = 6'($urandom_range(63));
    r.register_space = 2'($urandom_range(3));
    r.register_index = 6'($urandom_range(63));
    r.write_value    = $urandom;
    sel = $urandom_range(99);
    if (sel < 30) begin
      r.kind = KIND_REQUEST;
    end else if (sel < 50) begin
      r.kind           = KIND_READ;
      r.register_space = SPACE_CLAIM;
    end else if (sel < 65) begin
      r.kind           = KIND_WRITE;
      r.register_space = SPACE_CLAIM;
      for (int s = 1; s < NUM_SRC; s++) if (in_service_q[s]) busy_ids.push_back(s);
      if ($urandom_range(9) < 8) begin
        if (busy_ids.size() != 0)
          r.write_value = 32'(busy_ids[$urandom_range(busy_ids.size() - 1)]);
        else
          r.write_value = 32'($urandom_range(NUM_SRC - 1));
      end
    end else if (sel < 77) begin
      r.kind           = KIND_WRITE;
      r.register_space = SPACE_PRIORITY;
    end else if (sel < 82) begin
      r.kind           = KIND_WRITE;
      r.register_space = SPACE_ENABLE;
      if ($urandom_range(9) < 8) r.register_index = 6'($urandom_range(EN_WORDS - 1));
      if ($urandom_range(1) == 0) r.write_value = $urandom | $urandom;
    end else if (sel < 90) begin
      r.kind           = KIND_READ;
      r.register_space = $urandom_range(1) ? SPACE_ENABLE : SPACE_PRIORITY;
      if (r.register_space == SPACE_ENABLE && $urandom_range(9) < 8)
        r.register_index = 6'($urandom_range(EN_WORDS - 1));
    end
    return r;
  endfunction

  task automatic drive_txn(input req_t r, input bit typed, input rsp_t want);
    rsp_t got;
    int   gap;
    if (idle_on && $urandom_range(99) < 13) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    got = apply_transaction(r);
    rsp_backlog.push_back(typed ? want : got);
  endtask

  task automatic drain_responses();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (rsp_backlog.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [CFG_WIDTH-1:0] lvl);
    drain_responses();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lvl;
    threshold_q  = lvl;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (rsp_backlog.size() == 0) begin
        $display("%0t: result with none outstanding, actual %p", $time, rsp_o);
        mismatch_count++;
      end else begin
        want = rsp_backlog.pop_front();
        if (rsp_o.read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   want.read_value, rsp_o.read_value);
          mismatch_count++;
        end
        if (rsp_o.interrupt_line !== want.interrupt_line) begin
          $display("%0t: interrupt_line expected %b actual %b", $time,
                   want.interrupt_line, rsp_o.interrupt_line);
          mismatch_count++;
        end
        if (rsp_o.access_error !== want.access_error) begin
          $display("%0t: access_error expected %b actual %b", $time,
                   want.access_error, rsp_o.access_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) stall = 0;
      else stall++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    row_t plan [$];
    rsp_t none;
    int   phase_level [PHASES];
    int   lvl;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    threshold_q    = '0;
    mismatch_count = 0;
    idle_on        = 1'b1;
    none           = '0;
    phase_level    = '{0, 7, 3, 1, 5, 6, 0};
    foreach (level_q[s]) begin
      level_q[s]      = '0;
      enable_q[s]     = 1'b0;
      pending_q[s]    = 1'b0;
      in_service_q[s] = 1'b0;
    end

    plan.push_back(row(KIND_READ, 0, SPACE_PRIORITY, 5, 0, 1, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_CLAIM, 0, 0, 1, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_PRIORITY, 0, 32'hFFFF_FFFF, 1, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_PRIORITY, 0, 0, 1, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_PRIORITY, 63, 32'hFFFF_FFFF, 1, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_PRIORITY, 63, 0, 1, 7, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_ENABLE, 0, 32'hFFFF_FFFF, 1, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_ENABLE, 0, 0, 1, 32'hFFFF_FFFE, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_ENABLE, 1, 32'hFFFF_FFFF, 1, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_ENABLE, 1, 0, 1, 32'hFFFF_FFFF, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_ENABLE, 2, 32'hFFFF_FFFF, 1, 0, 0, 1));
    plan.push_back(row(KIND_READ, 0, SPACE_ENABLE, 63, 0, 1, 0, 0, 1));
    plan.push_back(row(KIND_REQUEST, 0, SPACE_PRIORITY, 0, 0, 1, 0, 0, 0));
    plan.push_back(row(KIND_REQUEST, 63, SPACE_PRIORITY, 0, 0, 1, 0, 1, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_PRIORITY, 1, 7, 0, 0, 0, 0));
    plan.push_back(row(KIND_REQUEST, 1, SPACE_PRIORITY, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_CLAIM, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_REQUEST, 1, SPACE_PRIORITY, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_CLAIM, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_CLAIM, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_CLAIM, 0, 64, 1, 0, 0, 1));
    plan.push_back(row(KIND_WRITE, 0, SPACE_CLAIM, 0, 32'hFFFF_FFFF, 1, 0, 0, 1));
    plan.push_back(row(KIND_WRITE, 0, SPACE_CLAIM, 0, 63, 0, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_PRIORITY, 63, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_REQUEST, 63, SPACE_PRIORITY, 0, 0, 0, 0, 0, 0));
    plan.push_back(row(KIND_UNUSED, 63, SPACE_PRIORITY, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    plan.push_back(row(KIND_WRITE, 0, SPACE_UNUSED, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    plan.push_back(row(KIND_READ, 0, SPACE_UNUSED, 63, 0, 0, 0, 0, 0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_threshold('0);

    foreach (plan[i]) drive_txn(plan[i].req, plan[i].typed, plan[i].want);

    for (int p = 0; p < PHASES; p++) begin
      lvl = (p == 4) ? $urandom_range(7) : phase_level[p];
      set_threshold(CFG_WIDTH'(lvl));
      idle_on = (p != 2);
      repeat (PHASE_ITEMS) drive_txn(random_txn(), 1'b0, none);
    end

    drain_responses();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
